FILE: hw/rtl/skt_pkg.sv
// Shared types, codes and defaults for the sorted key table.
package skt_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF      = 32;
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int FIELD_W  = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes carried on the input tuser.
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REWIND = 3'd4;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd5;

  // Result status codes carried on the output tuser.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_END       = 2'd3;

  // Per-cell move commands.
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_LEFT  = 2'd2;
  localparam logic [1:0] CELL_RIGHT = 2'd3;

  // Compare results that a cell reports to the controller.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

FILE: hw/rtl/skt_cell.sv
// One storage cell of the sorted key table: holds an entry, compares it, moves it.
module skt_cell #(
  parameter int KEY_WIDTH  = skt_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = skt_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic [1:0]              op,
  input  logic                    valid,
  input  logic [KEY_WIDTH-1:0]    cmp_key,
  input  logic [DATA_WIDTH-1:0]   new_payload,
  input  logic [KEY_WIDTH-1:0]    left_key,
  input  logic [DATA_WIDTH-1:0]   left_payload,
  input  logic [KEY_WIDTH-1:0]    right_key,
  input  logic [DATA_WIDTH-1:0]   right_payload,
  output logic [KEY_WIDTH-1:0]    key,
  output logic [DATA_WIDTH-1:0]   payload,
  output skt_pkg::cell_flags_t    flags
);

  // Compare the stored key against the broadcast request key.
  always_comb begin
    flags.lt = valid && (key < cmp_key);
    flags.eq = valid && (key == cmp_key);
  end

  // Entry register: hold, take the new entry, or take a neighbor's entry.
  always_ff @(posedge clk) begin
    case (op)
      skt_pkg::CELL_LOAD: begin
        key     <= cmp_key;
        payload <= new_payload;
      end
      skt_pkg::CELL_LEFT: begin
        key     <= left_key;
        payload <= left_payload;
      end
      skt_pkg::CELL_RIGHT: begin
        key     <= right_key;
        payload <= right_payload;
      end
      default: begin
        key     <= key;
        payload <= payload;
      end
    endcase
  end

endmodule

FILE: hw/rtl/sorted_key_table_unit.sv
// Sorted key table: a row of compare-and-shift cells kept in ascending key order.
//
// The table holds up to DEPTH key/payload entries, one per cell, in ascending
// unsigned key order. A request (operation on s_tuser, key and payload on
// s_tdata) is taken when idle and executed once the output register is free;
// no new request is taken before that. In the execute cycle every cell compares
// its key with the request key at once, and insert or delete shifts all later
// cells by one place toward their neighbor in that same cycle; no walk over the
// table is needed. Each request gives one result transaction (status on m_tuser,
// data and counts on m_tdata), held in an output register so that the next
// request can be taken while the result waits. There is no clearing pass after
// reset: a cell beyond the entry count is never read.
module sorted_key_table_unit #(
  parameter int DEPTH      = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = skt_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = skt_pkg::DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int OUT_BITS  = 2 * skt_pkg::FIELD_W + CW + 2,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request: s_tdata = {payload[63:32], key[31:0]}; s_tuser = func[2:0].
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [2*skt_pkg::FIELD_W-1:0]         s_tdata,
  input  logic [skt_pkg::FUNC_W-1:0]            s_tuser,
  // Result: m_tdata = out_key, out_payload, entry_count, is_full, is_empty
  // from the lowest bit up, zero padded; m_tuser = status[1:0].
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [OUT_W-1:0]                      m_tdata,
  output logic [skt_pkg::STATUS_W-1:0]          m_tuser
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = skt_pkg::FIELD_W;
  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0]                state;
  logic [skt_pkg::FUNC_W-1:0] req_func;
  logic [KEY_WIDTH-1:0]      req_key;
  logic [DATA_WIDTH-1:0]     req_payload;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [CW-1:0]             cursor;
  logic [CW-1:0]             cursor_next;

  logic [KEY_WIDTH-1:0]      cell_key     [DEPTH];
  logic [DATA_WIDTH-1:0]     cell_payload [DEPTH];
  skt_pkg::cell_flags_t      cell_flags   [DEPTH];
  logic [1:0]                cell_op      [DEPTH];
  logic [DEPTH-1:0]          valid;
  logic [DEPTH-1:0]          lt;
  logic [DEPTH-1:0]          prev_lt;
  logic [DEPTH-1:0]          hit;
  logic                      found;
  logic                      full;
  logic                      do_exec;
  logic                      accept;

  logic [KEY_WIDTH-1:0]      hit_key;
  logic [DATA_WIDTH-1:0]     hit_payload;
  logic [KEY_WIDTH-1:0]      res_key;
  logic [DATA_WIDTH-1:0]     res_payload;
  logic [skt_pkg::STATUS_W-1:0] res_status;
  logic [63:0]               in_key_ext;
  logic [63:0]               in_payload_ext;
  logic [63:0]               res_key_ext;
  logic [63:0]               res_payload_ext;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign do_exec  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign full     = (count == CW'(DEPTH));

  // Fit the fixed-width stream fields to the stored widths.
  assign in_key_ext     = {32'd0, s_tdata[FW-1:0]};
  assign in_payload_ext = {32'd0, s_tdata[2*FW-1:FW]};

  // Sequencer and request registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (accept) begin
      state <= S_EXEC;
    end else if (do_exec) begin
      state <= S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func    <= s_tuser;
      req_key     <= in_key_ext[KEY_WIDTH-1:0];
      req_payload <= in_payload_ext[DATA_WIDTH-1:0];
    end
  end

  // The row of cells, each wired to its left and right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]  l_key;
    logic [DATA_WIDTH-1:0] l_payload;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_payload;

    if (i == 0) begin : g_first
      assign l_key     = '0;
      assign l_payload = '0;
    end else begin : g_mid_l
      assign l_key     = cell_key[i-1];
      assign l_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key     = '0;
      assign r_payload = '0;
    end else begin : g_mid_r
      assign r_key     = cell_key[i+1];
      assign r_payload = cell_payload[i+1];
    end

    skt_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk           (clk),
      .op            (cell_op[i]),
      .valid         (valid[i]),
      .cmp_key       (req_key),
      .new_payload   (req_payload),
      .left_key      (l_key),
      .left_payload  (l_payload),
      .right_key     (r_key),
      .right_payload (r_payload),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .flags         (cell_flags[i])
    );
  end

  // Occupancy and compare flags; the lowest matching entry sits where the
  // run of smaller keys ends.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = (CW'(i) < count);
      lt[i]    = cell_flags[i].lt;
    end
    prev_lt = {lt[DEPTH-2:0], 1'b1};
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = cell_flags[i].eq && prev_lt[i];
    end
    found = |hit;
  end

  // Data of the matching cell, selected by its one-hot hit flag.
  always_comb begin
    hit_key     = '0;
    hit_payload = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        hit_key     = hit_key | cell_key[i];
        hit_payload = hit_payload | cell_payload[i];
      end
    end
  end

  // Cell moves, new counts and the result of the current request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = skt_pkg::CELL_HOLD;
    end
    count_next  = count;
    cursor_next = cursor;
    res_status  = skt_pkg::STAT_OK;
    res_key     = '0;
    res_payload = '0;

    case (req_func)
      skt_pkg::FN_INSERT: begin
        if (full) begin
          res_status = skt_pkg::STAT_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (lt[i]) begin
              cell_op[i] = skt_pkg::CELL_HOLD;
            end else if (prev_lt[i]) begin
              cell_op[i] = skt_pkg::CELL_LOAD;
            end else begin
              cell_op[i] = skt_pkg::CELL_LEFT;
            end
          end
          count_next = count + CW'(1);
        end
      end
      skt_pkg::FN_LOOKUP: begin
        if (found) begin
          res_key     = hit_key;
          res_payload = hit_payload;
        end else begin
          res_status = skt_pkg::STAT_NOT_FOUND;
        end
      end
      skt_pkg::FN_DELETE: begin
        if (found) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (!lt[i]) begin
              cell_op[i] = skt_pkg::CELL_RIGHT;
            end
          end
          count_next = count - CW'(1);
        end else begin
          res_status = skt_pkg::STAT_NOT_FOUND;
        end
      end
      skt_pkg::FN_CLEAR: begin
        count_next = '0;
      end
      skt_pkg::FN_REWIND: begin
        cursor_next = '0;
      end
      skt_pkg::FN_NEXT: begin
        if (cursor < count) begin
          res_key     = cell_key[cursor[IW-1:0]];
          res_payload = cell_payload[cursor[IW-1:0]];
          cursor_next = cursor + CW'(1);
        end else begin
          res_status = skt_pkg::STAT_END;
        end
      end
      default: begin
        res_status = skt_pkg::STAT_OK;
      end
    endcase

    // Nothing moves unless the request executes this cycle.
    if (!do_exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_op[i] = skt_pkg::CELL_HOLD;
      end
      count_next  = count;
      cursor_next = cursor;
    end
  end

  // Table count and read cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= '0;
    end else begin
      count  <= count_next;
      cursor <= cursor_next;
    end
  end

  assign res_key_ext     = 64'(res_key);
  assign res_payload_ext = 64'(res_payload);

  // Output register: loaded when a request executes, freed when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      m_tuser <= res_status;
      m_tdata <= OUT_W'({(count_next == '0),
                         (count_next == CW'(DEPTH)),
                         count_next,
                         res_payload_ext[FW-1:0],
                         res_key_ext[FW-1:0]});
    end
  end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the sorted key table with its own table predictor.
module tb_top;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_W       = ((2 * FIELD_W + CNT_W + 2 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // Operation codes the block does not define; they must leave the table alone.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  found_key;
    logic [FIELD_W-1:0]  found_payload;
    logic [CNT_W-1:0]    entry_count;
    logic                is_full;
    logic                is_empty;
  } table_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  fn;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
    logic               typed;
    table_result_t      want;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [2*FIELD_W-1:0]     s_tdata = '0;
  logic [FUNC_W-1:0]        s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_W-1:0]         m_tdata;
  logic [STATUS_W-1:0]      m_tuser;

  // Predicted table contents.
  logic [FIELD_W-1:0] tbl_keys [TABLE_DEPTH];
  logic [FIELD_W-1:0] tbl_payloads [TABLE_DEPTH];
  int                 tbl_count = 0;
  int                 tbl_cursor = 0;

  table_result_t pending_results [$];
  directed_row_t directed_rows [$];
  int            mismatch_count = 0;
  int            items_sent = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  bit            rx_hold_req = 1'b0;

  sorted_key_table_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Apply one request to the predicted table and return the result it gives.
  function automatic table_result_t apply_request(logic [FUNC_W-1:0] fn,
                                                  logic [FIELD_W-1:0] k,
                                                  logic [FIELD_W-1:0] d);
    table_result_t r;
    int loc;
    int hit;
    int i;
    r = '0;
    r.status = STAT_OK;
    hit = -1;
    for (i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_keys[i] == k) hit = i;
    end
    case (fn)
      FN_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          loc = 0;
          while (loc < tbl_count && tbl_keys[loc] < k) loc++;
          for (i = tbl_count; i > loc; i--) begin
            tbl_keys[i]     = tbl_keys[i-1];
            tbl_payloads[i] = tbl_payloads[i-1];
          end
          tbl_keys[loc]     = k;
          tbl_payloads[loc] = d;
          tbl_count++;
        end
      end
      FN_LOOKUP: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.found_key     = tbl_keys[hit];
          r.found_payload = tbl_payloads[hit];
        end
      end
      FN_DELETE: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (i = hit + 1; i < tbl_count; i++) begin
            tbl_keys[i-1]     = tbl_keys[i];
            tbl_payloads[i-1] = tbl_payloads[i];
          end
          tbl_count--;
        end
      end
      FN_CLEAR: tbl_count = 0;
      FN_REWIND: tbl_cursor = 0;
      FN_NEXT: begin
        if (tbl_cursor >= tbl_count) begin
          r.status = STAT_END;
        end else begin
          r.found_key     = tbl_keys[tbl_cursor];
          r.found_payload = tbl_payloads[tbl_cursor];
          tbl_cursor++;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(tbl_count);
    r.is_full     = (tbl_count == TABLE_DEPTH);
    r.is_empty    = (tbl_count == 0);
    return r;
  endfunction

  // Pick a key that often hits the extremes, a small range or a stored entry.
  function automatic logic [FIELD_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 5) return $urandom_range(0, 31);
    if (sel <= 7 && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    return $urandom;
  endfunction

  // Append a directed row; typed rows carry a result with zero data fields.
  task automatic add_row(logic [FUNC_W-1:0] fn, logic [FIELD_W-1:0] k,
                         logic [FIELD_W-1:0] d, logic typed,
                         logic [STATUS_W-1:0] st, int cnt);
    directed_row_t row;
    row.fn                 = fn;
    row.key                = k;
    row.payload            = d;
    row.typed              = typed;
    row.want.status        = st;
    row.want.found_key     = '0;
    row.want.found_payload = '0;
    row.want.entry_count   = CNT_W'(cnt);
    row.want.is_full       = (cnt == TABLE_DEPTH);
    row.want.is_empty      = (cnt == 0);
    directed_rows.push_back(row);
  endtask

  // Offer one request and record its expected result once the transaction is taken.
  task automatic send_request(logic [FUNC_W-1:0] fn, logic [FIELD_W-1:0] k,
                              logic [FIELD_W-1:0] d, logic typed,
                              table_result_t want);
    int gap;
    table_result_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {d, k};
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(fn, k, d);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Take the request stream off the bus without offering a new transaction.
  task automatic sender_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_random(logic [FUNC_W-1:0] fn, logic [FIELD_W-1:0] k);
    send_request(fn, k, $urandom, 1'b0, '0);
  endtask

  // Result side: random ready gaps, an occasional long hold-off, and checking.
  initial begin
    int gap;
    table_result_t want;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) rx_quiet = ~rx_quiet;
      // A requested hold-off is consumed here, so a request made later is kept.
      if (rx_hold_req) begin
        gap = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        $error("result with no pending request: status %0d", m_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[FIELD_W-1:0] !== want.found_key) begin
          $error("out_key: expected %h, got %h", want.found_key, m_tdata[FIELD_W-1:0]);
          mismatch_count++;
        end
        if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.found_payload) begin
          $error("out_payload: expected %h, got %h", want.found_payload,
                 m_tdata[2*FIELD_W-1:FIELD_W]);
          mismatch_count++;
        end
        if (m_tdata[2*FIELD_W +: CNT_W] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 m_tdata[2*FIELD_W +: CNT_W]);
          mismatch_count++;
        end
        if (m_tdata[2*FIELD_W+CNT_W] !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, m_tdata[2*FIELD_W+CNT_W]);
          mismatch_count++;
        end
        if (m_tdata[2*FIELD_W+CNT_W+1] !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty,
                 m_tdata[2*FIELD_W+CNT_W+1]);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random episodes, drain and verdict.
  initial begin
    int mode;
    int n;
    int sel;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: empty-table cases, extremes, duplicates, walk, clear and spare codes.
    add_row(FN_NEXT,    32'h0,        32'h0,        1'b1, STAT_END,       0);
    add_row(FN_LOOKUP,  32'h0,        32'h0,        1'b1, STAT_NOT_FOUND, 0);
    add_row(FN_DELETE,  32'hFFFFFFFF, 32'h0,        1'b1, STAT_NOT_FOUND, 0);
    add_row(FN_INSERT,  32'h0,        32'hFFFFFFFF, 1'b1, STAT_OK,        1);
    add_row(FN_INSERT,  32'hFFFFFFFF, 32'h0,        1'b1, STAT_OK,        2);
    add_row(FN_INSERT,  32'h5,        32'h1,        1'b0, STAT_OK,        0);
    add_row(FN_INSERT,  32'h5,        32'h2,        1'b0, STAT_OK,        0);
    add_row(FN_LOOKUP,  32'h5,        32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_LOOKUP,  32'hFFFFFFFF, 32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_LOOKUP,  32'h6,        32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_REWIND,  32'h0,        32'h0,        1'b1, STAT_OK,        4);
    repeat (5) add_row(FN_NEXT, 32'h0, 32'h0,       1'b0, STAT_OK,        0);
    add_row(FN_DELETE,  32'h5,        32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_LOOKUP,  32'h5,        32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_DELETE,  32'h0,        32'h0,        1'b0, STAT_OK,        0);
    add_row(FN_CLEAR,   32'h0,        32'h0,        1'b1, STAT_OK,        0);
    add_row(FN_NEXT,    32'h0,        32'h0,        1'b1, STAT_END,       0);
    add_row(FN_SPARE_6, 32'h0,        32'h0,        1'b1, STAT_OK,        0);
    add_row(FN_SPARE_7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, STAT_OK,        0);
    add_row(FN_INSERT,  32'h1,        32'hA5A5A5A5, 1'b0, STAT_OK,        0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].fn, directed_rows[i].key, directed_rows[i].payload,
                   directed_rows[i].typed, directed_rows[i].want);

    // Random episodes of well-formed sequences mixed with noise.
    while (items_sent < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);

      // Stall the result side while requests keep coming back to back.
      if (!hold_done && items_sent > 400) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        repeat (24) send_random(FN_INSERT, pick_key());
      end

      // Let every outstanding result come home before going on.
      if (!pause_done && items_sent > 800) begin
        pause_done = 1'b1;
        sender_idle();
        wait (pending_results.size() == 0);
      end

      mode = $urandom_range(0, 9);
      case (mode)
        // Fill to capacity, then push against the full table.
        0, 1: begin
          while (tbl_count < TABLE_DEPTH) send_random(FN_INSERT, pick_key());
          repeat ($urandom_range(1, 3)) send_random(FN_INSERT, pick_key());
        end
        // Drain by deleting stored keys, with some misses.
        2: begin
          while (tbl_count > 0) begin
            if ($urandom_range(0, 7) == 0) send_random(FN_DELETE, $urandom);
            else send_random(FN_DELETE, tbl_keys[$urandom_range(0, tbl_count - 1)]);
          end
        end
        // Walk the table in order past its end, sometimes editing mid-walk.
        3: begin
          send_random(FN_REWIND, pick_key());
          n = tbl_count + 2;
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) send_random(FN_INSERT, pick_key());
            else if ($urandom_range(0, 7) == 0) send_random(FN_DELETE, pick_key());
            send_random(FN_NEXT, pick_key());
          end
        end
        // Clear, then read on from a stale cursor.
        4: begin
          send_random(FN_CLEAR, pick_key());
          send_random(FN_NEXT, pick_key());
        end
        // Mixed operations with random content.
        default: begin
          repeat (8) begin
            sel = $urandom_range(0, 99);
            if (sel < 35)      send_random(FN_INSERT, pick_key());
            else if (sel < 60) send_random(FN_LOOKUP, pick_key());
            else if (sel < 80) send_random(FN_DELETE, pick_key());
            else if (sel < 90) send_random(FN_NEXT, pick_key());
            else if (sel < 95) send_random(FN_REWIND, pick_key());
            else if (sel < 97) send_random(FN_CLEAR, pick_key());
            else if (sel < 99) send_random(FN_SPARE_6, pick_key());
            else               send_random(FN_SPARE_7, pick_key());
          end
        end
      endcase
    end

    // Drain the results, watch for any stray transaction, then give the verdict.
    sender_idle();
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_key_table_unit regression: pass");
    end else begin
      $display("sorted_key_table_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20 * 400000);
    $display("sorted_key_table_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_unit.sv
verif/tb_top.sv
